/* rtl/core/gpiorb_pkg.sv */
// ----------------------------------------------------------------------------
// gpiorb_pkg
// Shared constants, register map and beat types of the GPIO register block.
// ----------------------------------------------------------------------------
package gpiorb_pkg;

   // pins actually implemented (0..53); port fields stay at FIELD_PINS bits
   localparam int NUM_PINS      = 54;
   localparam int FIELD_PINS    = 54;
   localparam int DATA_W        = 32;
   localparam int WORD_IDX_W    = 6;
   localparam int FSEL_W        = 3;
   localparam int PULL_W        = 2;
   localparam int PINS_PER_WORD = 10;
   localparam int FSEL_WORDS    = 6;

   localparam logic [63:0] PIN_MASK64 = (64'd1 << NUM_PINS) - 64'd1;

   // register map, word index = byte offset / 4
   localparam logic [WORD_IDX_W-1:0] W_SET0    = WORD_IDX_W'(32'h1c >> 2);
   localparam logic [WORD_IDX_W-1:0] W_SET1    = WORD_IDX_W'((32'h1c >> 2) + 1);
   localparam logic [WORD_IDX_W-1:0] W_CLR0    = WORD_IDX_W'(32'h28 >> 2);
   localparam logic [WORD_IDX_W-1:0] W_CLR1    = WORD_IDX_W'((32'h28 >> 2) + 1);
   localparam logic [WORD_IDX_W-1:0] W_LEV0    = WORD_IDX_W'(32'h34 >> 2);
   localparam logic [WORD_IDX_W-1:0] W_LEV1    = WORD_IDX_W'((32'h34 >> 2) + 1);
   localparam logic [WORD_IDX_W-1:0] W_PUD     = WORD_IDX_W'(32'h94 >> 2);
   localparam logic [WORD_IDX_W-1:0] W_PUDCLK0 = WORD_IDX_W'(32'h98 >> 2);
   localparam logic [WORD_IDX_W-1:0] W_PUDCLK1 = WORD_IDX_W'((32'h98 >> 2) + 1);

   localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'd1;
   localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd1;
   localparam logic [PULL_W-1:0] PULL_UP     = 2'd2;

   typedef struct packed {
      logic                  req_type;
      logic [WORD_IDX_W-1:0] word_index;
      logic [DATA_W-1:0]     wdata;
      logic [FIELD_PINS-1:0] pin_in;
   } req_beat_type;

   typedef struct packed {
      logic [DATA_W-1:0]     rdata;
      logic [FIELD_PINS-1:0] pin_drive_level;
      logic [FIELD_PINS-1:0] pin_drive_enable;
      logic [FIELD_PINS-1:0] pull_up_mask;
      logic [FIELD_PINS-1:0] pull_down_mask;
   } rsp_beat_type;

endpackage

/* rtl/core/gpiorb_if.sv */
// ----------------------------------------------------------------------------
// gpiorb_if
// Valid/ready channel interfaces for bus access beats and result beats.
// ----------------------------------------------------------------------------
interface gpiorb_req_if;
   import gpiorb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [WORD_IDX_W-1:0] word_index;
   logic [DATA_W-1:0]     wdata;
   logic [FIELD_PINS-1:0] pin_in;

   modport source (output valid, req_type, word_index, wdata, pin_in, input ready);
   modport sink   (input valid, req_type, word_index, wdata, pin_in, output ready);
endinterface

interface gpiorb_rsp_if;
   import gpiorb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [DATA_W-1:0]     rdata;
   logic [FIELD_PINS-1:0] pin_drive_level;
   logic [FIELD_PINS-1:0] pin_drive_enable;
   logic [FIELD_PINS-1:0] pull_up_mask;
   logic [FIELD_PINS-1:0] pull_down_mask;

   modport source (output valid, rdata, pin_drive_level, pin_drive_enable,
                   pull_up_mask, pull_down_mask, input ready);
   modport sink   (input valid, rdata, pin_drive_level, pin_drive_enable,
                   pull_up_mask, pull_down_mask, output ready);
endinterface

/* rtl/core/gpio_register_block_top.sv */
// ----------------------------------------------------------------------------
// gpio_register_block_top
// GPIO register block: function select, set/clear latch, levels and pulls.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries one bus access per beat: read/write flag, word index,
//    write data and the sampled pin levels. A beat moves when valid and
//    ready are both high at a rising clock edge.
//  - rsp_bus returns exactly one result beat per access, in order: read
//    data (zero for writes and unmapped words) and the pin drive, enable
//    and pull masks as they stand after that access.
//  - Path: an access taken at a rising edge waits in the input register;
//    its result beat is loaded into the result register when that is
//    free, and leaves from there.
//  - Throughput: one access per cycle while rsp ready stays high; the decode
//    and state update are combinational between the two registers.
//  - Stall: the result register holds its beat while rsp ready is low; the
//    input register still takes one more access, then req ready drops.
//  - Reset (synchronous, active high) empties both registers and returns
//    every pin to input, no pull, output latch clear, pull control zero.
// ----------------------------------------------------------------------------
module gpio_register_block_top (
   input logic          clock,
   input logic          reset,
   gpiorb_req_if.sink   req_bus,
   gpiorb_rsp_if.source rsp_bus
);
   import gpiorb_pkg::*;

   req_beat_type in_beat, held_beat;
   rsp_beat_type rsp_next, out_beat;
   logic         held_valid;
   logic         out_free;
   logic         advance;

   assign in_beat.req_type   = req_bus.req_type;
   assign in_beat.word_index = req_bus.word_index;
   assign in_beat.wdata      = req_bus.wdata;
   assign in_beat.pin_in     = req_bus.pin_in;

   // an access updates state only as its result enters the result register
   assign advance = held_valid && out_free;

   gpiorb_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_beat    (in_beat),
      .advance    (advance),
      .held_valid (held_valid),
      .held_beat  (held_beat)
   );

   gpiorb_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req      (held_beat),
      .rsp_next (rsp_next)
   );

   gpiorb_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_beat (rsp_next),
      .out_free  (out_free),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_beat  (out_beat)
   );

   assign rsp_bus.rdata            = out_beat.rdata;
   assign rsp_bus.pin_drive_level  = out_beat.pin_drive_level;
   assign rsp_bus.pin_drive_enable = out_beat.pin_drive_enable;
   assign rsp_bus.pull_up_mask     = out_beat.pull_up_mask;
   assign rsp_bus.pull_down_mask   = out_beat.pull_down_mask;
endmodule

/* rtl/core/gpiorb_in_stage.sv */
// ----------------------------------------------------------------------------
// gpiorb_in_stage
// Input register: holds one access beat until the core takes it.
// ----------------------------------------------------------------------------
module gpiorb_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  gpiorb_pkg::req_beat_type in_beat,
   input  logic                    advance,
   output logic                    held_valid,
   output gpiorb_pkg::req_beat_type held_beat
);
   import gpiorb_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff;

   // free when empty or emptying this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = 1'b0;
      if (in_valid && in_ready) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

   assign held_valid = valid_ff;
   assign held_beat  = beat_ff;
endmodule

/* rtl/core/gpiorb_core.sv */
// ----------------------------------------------------------------------------
// gpiorb_core
// Register state, address decode and next-result logic, one access per cycle while advance is high.
// ----------------------------------------------------------------------------
module gpiorb_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  gpiorb_pkg::req_beat_type req,
   output gpiorb_pkg::rsp_beat_type rsp_next
);
   import gpiorb_pkg::*;

   logic [NUM_PINS-1:0][FSEL_W-1:0] fsel_ff, fsel_in;
   logic [NUM_PINS-1:0][PULL_W-1:0] pull_ff, pull_in;
   logic [NUM_PINS-1:0]             latch_ff, latch_in;
   logic [PULL_W-1:0]               pull_ctl_ff, pull_ctl_in;

   logic              wr;
   logic              bank_hi;
   logic [63:0]       bank_vec;
   logic [NUM_PINS-1:0] pin_bank;
   logic [63:0]       pins64;
   logic [DATA_W-1:0] rd;
   logic [63:0]       lvl64, en64, up64, dn64;

   always_comb begin
      wr       = req.req_type;
      bank_hi  = (req.word_index == W_SET1) || (req.word_index == W_CLR1) ||
                 (req.word_index == W_PUDCLK1);
      bank_vec = bank_hi ? {req.wdata, 32'h0} : {32'h0, req.wdata};
      pin_bank = bank_vec[NUM_PINS-1:0];
      pins64   = 64'(req.pin_in) & PIN_MASK64;

      fsel_in     = fsel_ff;
      latch_in    = latch_ff;
      pull_in     = pull_ff;
      pull_ctl_in = pull_ctl_ff;
      rd          = '0;

      case (req.word_index)
         W_SET0, W_SET1: begin
            if (wr) latch_in = latch_ff | pin_bank;
         end
         W_CLR0, W_CLR1: begin
            if (wr) latch_in = latch_ff & ~pin_bank;
         end
         W_LEV0: begin
            if (!wr) rd = pins64[31:0];
         end
         W_LEV1: begin
            if (!wr) rd = pins64[63:32];
         end
         W_PUD: begin
            if (wr) pull_ctl_in = req.wdata[PULL_W-1:0];
            else    rd = DATA_W'(pull_ctl_ff);
         end
         W_PUDCLK0, W_PUDCLK1: begin
            if (wr) begin
               for (int i = 0; i < NUM_PINS; i++) begin
                  if (pin_bank[i]) pull_in[i] = pull_ctl_ff;
               end
            end
         end
         default: begin
            // function select words; each pin sits at a fixed word and slot
            for (int p = 0; p < NUM_PINS; p++) begin
               if (req.word_index == WORD_IDX_W'(p / PINS_PER_WORD)) begin
                  if (wr)
                     fsel_in[p] = req.wdata[FSEL_W*(p % PINS_PER_WORD) +: FSEL_W];
                  else
                     rd[FSEL_W*(p % PINS_PER_WORD) +: FSEL_W] = fsel_ff[p];
               end
            end
         end
      endcase

      lvl64 = 64'(latch_in);
      en64  = '0;
      up64  = '0;
      dn64  = '0;
      for (int i = 0; i < NUM_PINS; i++) begin
         en64[i] = (fsel_in[i] == FSEL_OUTPUT);
         up64[i] = (pull_in[i] == PULL_UP);
         dn64[i] = (pull_in[i] == PULL_DOWN);
      end

      rsp_next.rdata            = wr ? '0 : rd;
      rsp_next.pin_drive_level  = lvl64[FIELD_PINS-1:0];
      rsp_next.pin_drive_enable = en64[FIELD_PINS-1:0];
      rsp_next.pull_up_mask     = up64[FIELD_PINS-1:0];
      rsp_next.pull_down_mask   = dn64[FIELD_PINS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff     <= '0;
         pull_ff     <= '0;
         latch_ff    <= '0;
         pull_ctl_ff <= '0;
      end else if (advance) begin
         fsel_ff     <= fsel_in;
         pull_ff     <= pull_in;
         latch_ff    <= latch_in;
         pull_ctl_ff <= pull_ctl_in;
      end
   end
endmodule

/* rtl/core/gpiorb_out_stage.sv */
// ----------------------------------------------------------------------------
// gpiorb_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module gpiorb_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  gpiorb_pkg::rsp_beat_type load_beat,
   output logic                    out_free,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gpiorb_pkg::rsp_beat_type out_beat
);
   import gpiorb_pkg::*;

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff;

   assign out_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && out_ready) valid_in = 1'b0;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= load_beat;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;
endmodule

/* rtl/core/gpiorb_checker.sv */
// ----------------------------------------------------------------------------
// gpiorb_rsp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gpiorb_rsp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [gpiorb_pkg::DATA_W-1:0]       rsp_rdata,
   input logic [gpiorb_pkg::FIELD_PINS-1:0]   rsp_up,
   input logic [gpiorb_pkg::FIELD_PINS-1:0]   rsp_dn
);
   import gpiorb_pkg::*;

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // a pin cannot be pulled both ways
   a_pull_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_up & rsp_dn) == '0))
      else $error("pull up and pull down set on the same pin");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled result beat dropped");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_rdata))
      else $error("stalled result beat changed");
endmodule

bind gpio_register_block_top gpiorb_rsp_checker u_gpiorb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_rdata (rsp_bus.rdata),
   .rsp_up    (rsp_bus.pull_up_mask),
   .rsp_dn    (rsp_bus.pull_down_mask)
);
